[rtl/core/sod_pkg.sv]
// Package for the divisor-sum block: widths, prime ROM, sequencer states and
// the divider status struct. No dependencies.
`default_nettype none

package sod_pkg;

    localparam int VALUE_BITS_DEF  = 20;
    localparam int PRIME_COUNT_DEF = 172;
    localparam int ROM_DEPTH       = 172;
    localparam int ROM_IDX_BITS    = 8;
    localparam int PRIME_BITS      = 10;
    localparam int SUM_BITS        = 24;

    // Primes 2..1021 in rising order.
    localparam logic [PRIME_BITS-1:0] PRIME_ROM [ROM_DEPTH] = '{
        10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
        10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
        10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109,
        10'd113, 10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163,
        10'd167, 10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211,
        10'd223, 10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313,
        10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373,
        10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431,
        10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479,
        10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547,
        10'd557, 10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601,
        10'd607, 10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653,
        10'd659, 10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769, 10'd773,
        10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827, 10'd829, 10'd839,
        10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907,
        10'd911, 10'd919, 10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971,
        10'd977, 10'd983, 10'd991, 10'd997, 10'd1009, 10'd1013, 10'd1019, 10'd1021
    };

    function automatic logic [PRIME_BITS-1:0] prime_at(input logic [ROM_IDX_BITS-1:0] idx);
        logic [PRIME_BITS-1:0] p;
        p = '0;
        if (int'(idx) < ROM_DEPTH)
        begin
            p = PRIME_ROM[idx];
        end
        return p;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_DIV,
        ST_POWER,
        ST_MERGE,
        ST_FINAL,
        ST_FIN_MUL,
        ST_DONE
    } sod_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

[rtl/core/sod_divider.sv]
// Restoring divider, one quotient bit per cycle, for the trial divisions.
// Depends on sod_pkg.
`default_nettype none

module sod_divider #(
    parameter int VALUE_BITS = sod_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [VALUE_BITS-1:0]           dividend,
    input  wire logic [sod_pkg::PRIME_BITS-1:0]  divisor,
    output logic [VALUE_BITS-1:0]                quotient,
    output logic [sod_pkg::PRIME_BITS-1:0]       remainder,
    output sod_pkg::div_status_t                 status
);
    import sod_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [PRIME_BITS-1:0] r_reg, r_next;
    logic [PRIME_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PRIME_BITS:0]   trial;
    logic [PRIME_BITS:0]   diff;
    logic                  fits;

    always_comb
    begin
        trial     = {r_reg, q_reg[VALUE_BITS-1]};
        diff      = trial - {1'b0, d_reg};
        fits      = trial >= {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_BITS'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and subtract when it fits.
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            r_next   = fits ? diff[PRIME_BITS-1:0] : trial[PRIME_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient    = q_reg;
    assign remainder   = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

[rtl/core/sod_multiplier.sv]
// Shared multiplier with a registered product, kept modulo 2^SUM_BITS.
// Depends on sod_pkg.
`default_nettype none

module sod_multiplier (
    input  wire logic                          clk,
    input  wire logic                          start,
    input  wire logic [sod_pkg::SUM_BITS-1:0]  op_a,
    input  wire logic [sod_pkg::SUM_BITS-1:0]  op_b,
    output logic [sod_pkg::SUM_BITS-1:0]       product
);
    import sod_pkg::*;

    logic [2*SUM_BITS-1:0] full;
    logic [SUM_BITS-1:0]   prod_reg, prod_next;

    always_comb
    begin
        full      = op_a * op_b;
        prod_next = start ? full[SUM_BITS-1:0] : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

[rtl/core/sum_of_divisors.sv]
// Divisor sum by trial division: each prime tried takes one pass of the bit-serial divider,
// each prime factor power a further division and multiply, and each distinct prime factor
// a merge multiply; with default parameters up to 172 primes are tried per transaction,
// fewer when p*p passes the cofactor early. One transaction at a time; the result register
// lets the next input be taken while a result waits. Reset clears the sequencer and the output valid flag.
// Depends on sod_pkg, sod_divider and sod_multiplier.
`default_nettype none

module sum_of_divisors #(
    parameter int VALUE_BITS  = sod_pkg::VALUE_BITS_DEF,
    parameter int PRIME_COUNT = sod_pkg::PRIME_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [VALUE_BITS-1:0]         value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sod_pkg::SUM_BITS-1:0]       divisor_sum
);
    import sod_pkg::*;

    localparam int LIMIT    = (PRIME_COUNT < ROM_DEPTH) ? PRIME_COUNT : ROM_DEPTH;
    localparam int IDX_BITS = $clog2(LIMIT + 1);
    localparam int CMP_BITS = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;

    sod_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [SUM_BITS-1:0]   result_reg, result_next;
    logic [SUM_BITS-1:0]   power_reg, power_next;
    logic [SUM_BITS-1:0]   partial_reg, partial_next;
    logic                  hit_reg, hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]   out_data_reg, out_data_next;

    logic [PRIME_BITS-1:0] prime;
    logic [VALUE_BITS:0]   n_inc;
    logic                  mul_start;
    logic [SUM_BITS-1:0]   mul_a, mul_b, mul_prod;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_quot;
    logic [PRIME_BITS-1:0] div_rem;
    div_status_t           div_stat;
    logic                  in_fire;

    assign prime   = prime_at(ROM_IDX_BITS'(idx_reg));
    assign n_inc   = {1'b0, n_reg} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign in_fire = in_valid && in_ready;

    sod_multiplier u_mul (
        .clk     (clk),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod)
    );

    sod_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (prime),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        result_next    = result_reg;
        power_next     = power_reg;
        partial_next   = partial_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        mul_start      = 1'b0;
        mul_a          = SUM_BITS'(prime);
        mul_b          = SUM_BITS'(prime);
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next      = value;
                    result_next = SUM_BITS'(1);
                    idx_next    = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (idx_reg == IDX_BITS'(LIMIT))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    mul_start    = 1'b1;
                    power_next   = SUM_BITS'(1);
                    partial_next = SUM_BITS'(1);
                    hit_next     = 1'b0;
                    state_next   = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (CMP_BITS'(mul_prod) > CMP_BITS'(n_reg))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_rem == '0)
                    begin
                        n_next     = div_quot;
                        hit_next   = 1'b1;
                        mul_start  = 1'b1;
                        mul_a      = power_reg;
                        state_next = ST_POWER;
                    end
                    else if (hit_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = result_reg;
                        mul_b      = partial_reg;
                        state_next = ST_MERGE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_BITS'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_POWER:
            begin
                power_next   = mul_prod;
                partial_next = partial_reg + mul_prod;
                div_start    = 1'b1;
                state_next   = ST_DIV;
            end
            ST_MERGE:
            begin
                result_next = mul_prod;
                idx_next    = idx_reg + IDX_BITS'(1);
                state_next  = ST_CHECK;
            end
            ST_FINAL:
            begin
                // A cofactor above one is a prime and adds the factor (cofactor + 1).
                if (n_reg > VALUE_BITS'(1))
                begin
                    mul_start  = 1'b1;
                    mul_a      = result_reg;
                    mul_b      = SUM_BITS'(n_inc);
                    state_next = ST_FIN_MUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIN_MUL:
            begin
                result_next = mul_prod;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        result_reg   <= result_next;
        power_reg    <= power_next;
        partial_reg  <= partial_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_data_reg;

    // The divider is never restarted while a division is still running.
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // An accepted transaction always leaves the idle state.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after input transaction");

    // The prime index never runs past the end of the table in use.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_BITS'(LIMIT))
        else $error("prime index out of range");

    // A division result is only consumed while waiting for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("division finished outside the divide step");

endmodule

`default_nettype wire
